/* rtl/tstc_pkg.sv */
// shared types, constants and state encoding for the three-sum triple counter
`timescale 1ns / 1ps

package tstc_pkg;

    localparam int MAX_VALUES_DEF = 64;
    localparam int VALUE_W        = 32;
    localparam int TALLY_W        = 16;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_value;
    } in_item_t;

    typedef struct packed {
        logic [TALLY_W-1:0] triple_count;
        logic               overflow;
    } out_item_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic store_write;
        logic read;
        logic load_vi;
        logic load_pair;
        logic check;
        logic clear_set;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_START,
        ST_PAIR_I,
        ST_PAIR_J,
        ST_PAIR_SUM,
        ST_K_LOOP,
        ST_FLUSH,
        ST_DONE
    } state_t;

endpackage

/* rtl/three_sum_triple_counter.sv */
// top level of the three-sum triple counter
`timescale 1ns / 1ps

// usage
// input: one signed 32-bit value per transaction, taken at a rising edge with
//   start high and busy low; last_value closes the set
// values arriving while MAX_VALUES are already stored are dropped and set the
//   overflow bit of the result
// loading takes one value per cycle, busy stays low during loading
// after the final transaction busy rises and the block scans every triple
//   i < j < k of the n stored values: the states PAIR_I, PAIR_J and PAIR_SUM
//   set up each pair (i, j) and one k per cycle follows in K_LOOP, streamed
//   through the single store read port
// output: done is high for exactly one cycle with triple_count and overflow on
//   result; the receiver cannot stall, the result is taken in that cycle
// the cycle after done the block is idle and empty for the next set
// reset clears the set count, overflow bit, tally and sequencer; store
//   contents need no clearing since only entries of the current set are read
module three_sum_triple_counter #(
    parameter int MAX_VALUES = tstc_pkg::MAX_VALUES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tstc_pkg::in_item_t  item,
    output logic                busy,
    output logic                done,
    output tstc_pkg::out_item_t result
);

    import tstc_pkg::*;

    localparam int IDX_W = $clog2(MAX_VALUES);
    localparam int CNT_W = $clog2(MAX_VALUES + 1);

    cmd_t             cmd;
    logic [IDX_W-1:0] raddr;
    logic [CNT_W-1:0] n;

    tstc_ctrl #(
        .MAX_VALUES (MAX_VALUES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_value (item.last_value),
        .n          (n),
        .cmd        (cmd),
        .raddr      (raddr),
        .busy       (busy),
        .done       (done)
    );

    tstc_datapath #(
        .MAX_VALUES (MAX_VALUES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .raddr  (raddr),
        .item   (item),
        .n      (n),
        .result (result)
    );

endmodule

/* rtl/tstc_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tstc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/tstc_ctrl.sv */
// sequencer: load phase, triple scan over (i, j, k) and result strobe
`timescale 1ns / 1ps

module tstc_ctrl #(
    parameter int MAX_VALUES = tstc_pkg::MAX_VALUES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             last_value,
    input  logic [$clog2(MAX_VALUES+1)-1:0]  n,
    output tstc_pkg::cmd_t                   cmd,
    output logic [$clog2(MAX_VALUES)-1:0]    raddr,
    output logic                             busy,
    output logic                             done
);

    import tstc_pkg::*;

    localparam int IDX_W = $clog2(MAX_VALUES);
    localparam int CNT_W = $clog2(MAX_VALUES + 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             accept;
    logic             last_k, last_j, last_i;

    assign accept = start && (state_reg == ST_IDLE);
    assign last_k = (CNT_W'(k_reg) + CNT_W'(1)) == n;
    assign last_j = (CNT_W'(j_reg) + CNT_W'(2)) == n;
    assign last_i = (CNT_W'(i_reg) + CNT_W'(3)) == n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // next state and scan indices
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_value)
                begin
                    state_next = ST_SCAN_START;
                end
            end
            ST_SCAN_START:
            begin
                i_next = '0;
                j_next = IDX_W'(1);
                if (n < CNT_W'(3))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PAIR_I;
                end
            end
            ST_PAIR_I:
            begin
                state_next = ST_PAIR_J;
            end
            ST_PAIR_J:
            begin
                state_next = ST_PAIR_SUM;
            end
            ST_PAIR_SUM:
            begin
                k_next     = j_reg + IDX_W'(1);
                state_next = ST_K_LOOP;
            end
            ST_K_LOOP:
            begin
                if (!last_k)
                begin
                    k_next = k_reg + IDX_W'(1);
                end
                else if (!last_j)
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = ST_PAIR_I;
                end
                else if (!last_i)
                begin
                    i_next     = i_reg + IDX_W'(1);
                    j_next     = i_reg + IDX_W'(2);
                    state_next = ST_PAIR_I;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command decode
    always_comb
    begin
        cmd   = '0;
        raddr = i_reg;
        busy  = 1'b1;
        done  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy            = 1'b0;
                cmd.store_write = accept;
            end
            ST_PAIR_I:
            begin
                cmd.read = 1'b1;
                raddr    = i_reg;
            end
            ST_PAIR_J:
            begin
                cmd.read    = 1'b1;
                cmd.load_vi = 1'b1;
                raddr       = j_reg;
            end
            ST_PAIR_SUM:
            begin
                cmd.load_pair = 1'b1;
            end
            ST_K_LOOP:
            begin
                cmd.read  = 1'b1;
                cmd.check = 1'b1;
                raddr     = k_reg;
            end
            ST_DONE:
            begin
                done          = 1'b1;
                cmd.clear_set = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_value) |=> (state_reg == ST_SCAN_START))
        else $error("final transaction did not start the scan");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block stayed busy after the result");

    a_k_above_j: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_K_LOOP) |-> (k_reg > j_reg))
        else $error("third index not above second index");

    a_j_above_i: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_K_LOOP) |-> (j_reg > i_reg))
        else $error("second index not above first index");

endmodule

/* rtl/tstc_datapath.sv */
// datapath: value store, set count, pair sum and zero-sum tally
`timescale 1ns / 1ps

module tstc_datapath #(
    parameter int MAX_VALUES = tstc_pkg::MAX_VALUES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tstc_pkg::cmd_t                   cmd,
    input  logic [$clog2(MAX_VALUES)-1:0]    raddr,
    input  tstc_pkg::in_item_t               item,
    output logic [$clog2(MAX_VALUES+1)-1:0]  n,
    output tstc_pkg::out_item_t              result
);

    import tstc_pkg::*;

    localparam int IDX_W = $clog2(MAX_VALUES);
    localparam int CNT_W = $clog2(MAX_VALUES + 1);

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      dropped_reg, dropped_next;
    logic                      check_reg;
    logic [TALLY_W-1:0]        tally_reg, tally_next;
    logic signed [VALUE_W-1:0] vi_reg;
    logic signed [VALUE_W:0]   pair_reg;
    logic [VALUE_W-1:0]        rdata;
    logic                      full;
    logic                      write_en;
    logic signed [VALUE_W+1:0] triple_sum;

    assign full     = count_reg == CNT_W'(MAX_VALUES);
    assign write_en = cmd.store_write && !full;

    tstc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_VALUES)
    ) u_store (
        .clk   (clk),
        .we    (write_en),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (item.value),
        .re    (cmd.read),
        .raddr (raddr),
        .rdata (rdata)
    );

    // full-width sum, never wraps
    assign triple_sum = (VALUE_W+2)'(pair_reg) + (VALUE_W+2)'($signed(rdata));

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        tally_next   = tally_reg;
        if (cmd.clear_set)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
            tally_next   = '0;
        end
        else
        begin
            if (write_en)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (cmd.store_write)
            begin
                dropped_next = 1'b1;
            end
            // saturate at the top of the tally
            if (check_reg && (triple_sum == '0) && (tally_reg != '1))
            begin
                tally_next = tally_reg + TALLY_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            tally_reg   <= '0;
            check_reg   <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            tally_reg   <= tally_next;
            check_reg   <= cmd.check;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_vi)
        begin
            vi_reg <= $signed(rdata);
        end
        if (cmd.load_pair)
        begin
            pair_reg <= (VALUE_W+1)'(vi_reg) + (VALUE_W+1)'($signed(rdata));
        end
    end

    assign n                   = count_reg;
    assign result.triple_count = tally_reg;
    assign result.overflow     = dropped_reg;

endmodule

/* verif/tb_three_sum_triple_counter.sv */
// self-checking testbench for the three-sum triple counter: queued sets, predicted zero-sum counts
`timescale 1ns / 1ps

module tb_three_sum_triple_counter;

    import tstc_pkg::*;

    localparam int STORE_DEPTH = MAX_VALUES_DEF;
    localparam int ITEM_TARGET = 920;
    localparam int QUIET_TAIL  = 100;
    localparam int SETTLE_CYC  = 20;
    localparam int unsigned TALLY_SAT = 65535;

    localparam int MODE_SMALL   = 0;
    localparam int MODE_FULL    = 1;
    localparam int MODE_EXTREME = 2;
    localparam int MODE_TRIPLE  = 3;
    localparam int MODE_ZERO    = 4;

    typedef struct {
        in_item_t item;
        bit       drain_first;
        bit       allow_gap;
    } pending_t;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  item  = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    pending_t  pending_q[$];
    out_item_t expected_counts_q[$];

    // predictor state for the set being loaded
    logic signed [VALUE_W-1:0] set_vals [STORE_DEPTH];
    int        stored_n;
    bit        set_dropped;

    int        gap_left;
    bit        cur_allow_gap;
    bit        launch;
    pending_t  nxt;
    bit        next_drain;

    int        fail_count;
    int        items_taken;
    int        results_checked;
    int        overflow_results;
    int        peak_count;

    three_sum_triple_counter #(
        .MAX_VALUES(STORE_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [TALLY_W-1:0] count_zero_triples(input int n);
        int          i;
        int          j;
        int          k;
        int unsigned tally;
        longint      s;
        tally = 0;
        for (i = 0; i < n; i++)
        begin
            for (j = i + 1; j < n; j++)
            begin
                for (k = j + 1; k < n; k++)
                begin
                    // full-width sum, no 32-bit wrap
                    s = longint'(set_vals[i]) + longint'(set_vals[j]) + longint'(set_vals[k]);
                    if (s == 0 && tally < TALLY_SAT)
                        tally++;
                end
            end
        end
        return tally[TALLY_W-1:0];
    endfunction

    task automatic absorb_value(input in_item_t it);
        out_item_t exp_res;
        if (stored_n < STORE_DEPTH)
        begin
            set_vals[stored_n] = it.value;
            stored_n++;
        end
        else
            set_dropped = 1'b1;
        if (it.last_value)
        begin
            exp_res.triple_count = count_zero_triples(stored_n);
            exp_res.overflow     = set_dropped;
            expected_counts_q.push_back(exp_res);
            stored_n    = 0;
            set_dropped = 1'b0;
        end
    endtask

    // driver: one transaction per accepted edge, random idle bursts between them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                absorb_value(item);
                items_taken++;
                if (cur_allow_gap && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 3);
                launch = 1'b1;
            end
            else
                launch = !start;
            if (launch)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain_first && expected_counts_q.size() > 0))
                begin
                    nxt = pending_q.pop_front();
                    item <= nxt.item;
                    start <= 1'b1;
                    cur_allow_gap = nxt.allow_gap;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every done strobe must match the oldest predicted count
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_counts_q.size() == 0)
            begin
                $error("unexpected result: triple_count %0d overflow %0d",
                       result.triple_count, result.overflow);
                fail_count++;
            end
            else
            begin
                out_item_t exp_res;
                exp_res = expected_counts_q.pop_front();
                results_checked++;
                if (exp_res.overflow)
                    overflow_results++;
                if (int'(exp_res.triple_count) > peak_count)
                    peak_count = int'(exp_res.triple_count);
                if (result.triple_count !== exp_res.triple_count)
                begin
                    $error("triple_count: expected %0d, actual %0d",
                           exp_res.triple_count, result.triple_count);
                    fail_count++;
                end
                if (result.overflow !== exp_res.overflow)
                begin
                    $error("overflow: expected %0d, actual %0d",
                           exp_res.overflow, result.overflow);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_value(input logic signed [VALUE_W-1:0] v, input bit last);
        pending_t p;
        p.item.value      = v;
        p.item.last_value = last;
        p.drain_first     = next_drain;
        p.allow_gap       = 1'b1;
        next_drain        = 1'b0;
        pending_q.push_back(p);
    endtask

    task automatic make_set(input int n, input int mode);
        int     i;
        longint prev1;
        longint prev2;
        longint c;
        logic signed [VALUE_W-1:0] v;
        prev1 = 0;
        prev2 = 0;
        for (i = 0; i < n; i++)
        begin
            case (mode)
                MODE_SMALL:   v = int'($urandom_range(0, 8)) - 4;
                MODE_FULL:    v = $urandom;
                MODE_EXTREME:
                    case ($urandom_range(0, 7))
                        0: v = 32'sh8000_0000;
                        1: v = 32'sh7FFF_FFFF;
                        2: v = 32'sh8000_0001;
                        3: v = -1;
                        4: v = 0;
                        5: v = 1;
                        6: v = 32'sh4000_0000;
                        default: v = 32'shC000_0000;
                    endcase
                MODE_TRIPLE:
                begin
                    // every third value cancels the two before it, or is zero when that value would not fit in 32 bits
                    if (i % 3 == 2)
                    begin
                        c = -(prev1 + prev2);
                        if (c > 64'sd2147483647 || c < -64'sd2147483648)
                            c = 0;
                        v = c[VALUE_W-1:0];
                    end
                    else if ($urandom_range(0, 1) == 0)
                        v = int'($urandom_range(0, 12)) - 6;
                    else
                        v = $urandom;
                end
                default:      v = 0;
            endcase
            prev2 = prev1;
            prev1 = longint'(v);
            push_value(v, i == n - 1);
        end
    endtask

    initial
    begin
        int rand_sets;
        int size;
        int i;
        int total_sets;
        stored_n         = 0;
        set_dropped      = 1'b0;
        gap_left         = 0;
        cur_allow_gap    = 1'b0;
        next_drain       = 1'b0;
        fail_count       = 0;
        items_taken      = 0;
        results_checked  = 0;
        overflow_results = 0;
        peak_count       = 0;
        rand_sets        = 0;

        // directed sets
        push_value(0, 1'b1);                        // single value
        push_value(32'sh7FFF_FFFF, 1'b0);           // two values, no triple
        push_value(32'sh8000_0000, 1'b1);
        push_value(0, 1'b0);
        push_value(0, 1'b0);
        push_value(0, 1'b1);
        next_drain = 1'b1;
        push_value(32'sh8000_0000, 1'b0);           // extremes that cancel exactly
        push_value(32'sh7FFF_FFFF, 1'b0);
        push_value(1, 1'b1);
        push_value(32'sh7FFF_FFFF, 1'b0);           // wraps to zero only at 32 bits
        push_value(32'sh7FFF_FFFF, 1'b0);
        push_value(2, 1'b1);
        push_value(32'sh8000_0000, 1'b0);
        push_value(32'sh8000_0000, 1'b0);
        push_value(32'sh8000_0000, 1'b1);
        push_value(5, 1'b0);
        push_value(-2, 1'b0);
        push_value(-3, 1'b0);
        push_value(1, 1'b0);
        push_value(2, 1'b0);
        push_value(-1, 1'b0);
        push_value(0, 1'b1);

        // random sets, a few filling or overrunning the store
        while (pending_q.size() < ITEM_TARGET)
        begin
            if (rand_sets % 10 == 9)
                next_drain = 1'b1;
            case (rand_sets)
                4:  make_set(STORE_DEPTH + 1, MODE_ZERO);   // peak count, last one dropped
                25: make_set(STORE_DEPTH, MODE_SMALL);      // exactly full
                50: make_set(STORE_DEPTH + 6, MODE_TRIPLE);
                75: make_set(STORE_DEPTH, MODE_EXTREME);
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                        size = $urandom_range(1, 2);
                    else
                        size = $urandom_range(3, 12);
                    make_set(size, $urandom_range(0, 9) < 4 ? MODE_TRIPLE :
                                   $urandom_range(MODE_SMALL, MODE_EXTREME));
                end
            endcase
            rand_sets++;
        end
        total_sets = rand_sets + 7;

        for (i = pending_q.size() - QUIET_TAIL; i < pending_q.size(); i++)
            pending_q[i].allow_gap = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() > 0 || start || expected_counts_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        $display("sent %0d values in %0d sets; %0d counts checked, %0d with dropped values",
                 items_taken, total_sets, results_checked, overflow_results);
        $display("largest predicted count %0d", peak_count);
        if (fail_count == 0)
            $display("tb_three_sum_triple_counter OK");
        else
            $display("tb_three_sum_triple_counter NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_three_sum_triple_counter NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tstc_pkg.sv
rtl/tstc_ram.sv
rtl/tstc_ctrl.sv
rtl/tstc_datapath.sv
rtl/three_sum_triple_counter.sv
verif/tb_three_sum_triple_counter.sv
